>>> rtl/lrukv_pkg.sv
package lrukv_pkg;

    // Store geometry.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    // Field widths.
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Request operation codes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Value returned by a get that misses.
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // Value memory access for one cycle.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [VAL_W-1:0] wr_data;
    } ram_req_t;

endpackage

>>> rtl/lrukv_if.sv
// Request channel: one get or put per transaction.
interface lrukv_req_if;
    import lrukv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

// Response channel: one result per request.
interface lrukv_resp_if;
    import lrukv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;

    modport source (output valid, output found, output read_value, output evicted,
                    input ready);
    modport sink   (input valid, input found, input read_value, input evicted,
                    output ready);
endinterface

// Configuration channel: writes the capacity register.
interface lrukv_cfg_if;
    import lrukv_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

>>> rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement. It
// handles one transaction at a time. A get passes from acceptance to a result in
// the output register through a registered compare of the key against all
// entries and a rank update (with the value memory read); a put adds to these
// the eviction and insert step that writes the value memory. The next request
// is accepted once the block is back in idle, while the previous result may
// still wait in the output register; a result that is still waiting when the
// next one is ready holds the block until it is taken. Keys, valid bits
// and recency ranks live in flip-flops so every key can be compared at once;
// values live in a single-read, single-write memory. Reset empties the store at
// once, so no clearing pass is needed. Capacity may be written only while the
// block is idle; a value of 0 acts as 1 and values above the entry count act as
// the entry count.
module lru_key_value_cache (
    input  logic         clk,
    input  logic         rst_n,
    lrukv_req_if.sink    req,
    lrukv_resp_if.source resp,
    lrukv_cfg_if.sink    cfg
);
    import lrukv_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_REMOVE = 5'b00100,
        S_INSERT = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Request latched at acceptance.
    logic             op_reg;
    logic [KEY_W-1:0] key_in_reg;
    logic [VAL_W-1:0] val_in_reg;

    // Store state.
    logic [KEY_W-1:0]   key_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [RANK_W-1:0]  rank_reg [ENTRIES];
    logic [RANK_W-1:0]  rank_next [ENTRIES];
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [CAP_W-1:0]   cap_reg;

    // Per-request intermediate results.
    logic [ENTRIES-1:0] match_reg, match_next;
    logic               found_reg;
    logic               evicted_reg;

    // Output register.
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_evicted_reg;

    // Value memory.
    ram_req_t         ram_req;
    logic [VAL_W-1:0] ram_rd_data;

    // Rank update and insert signals.
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [RANK_W-1:0]  hit_rank;
    logic [ENTRIES-1:0] rem_valid;
    logic [RANK_W-1:0]  rem_rank [ENTRIES];
    logic [OCC_W-1:0]   rem_occ;
    logic [CMP_W-1:0]   cap_wide;
    logic [OCC_W-1:0]   cap_eff;
    logic [OCC_W-1:0]   cap_m1;
    logic               full;
    logic [ENTRIES-1:0] ev_mask;
    logic [ENTRIES-1:0] kept_valid;
    logic [OCC_W-1:0]   kept_occ;
    logic [IDX_W-1:0]   ins_idx;
    logic [ENTRIES-1:0] ins_valid;
    logic [RANK_W-1:0]  ins_rank [ENTRIES];
    logic               out_load;

    lrukv_value_ram u_value_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    // Handshakes.
    assign req.ready  = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign out_load   = (state_reg == S_FINISH) && (!out_valid_reg || resp.ready);

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.capacity;
        end
    end

    // Effective capacity, clamped to one through the entry count.
    always_comb
    begin
        cap_wide = CMP_W'(cap_reg);
        if (cap_wide == '0)
        begin
            cap_eff = OCC_W'(1);
        end
        else if (cap_wide > CMP_W'(ENTRIES))
        begin
            cap_eff = OCC_W'(ENTRIES);
        end
        else
        begin
            cap_eff = OCC_W'(cap_wide);
        end
        cap_m1 = cap_eff - OCC_W'(1);
    end

    // Parallel key compare against every valid entry.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_next[i] = valid_reg[i] && (key_reg[i] == key_in_reg);
        end
    end

    // Hit decode and removal or promotion of the hit entry.
    always_comb
    begin
        hit      = |match_reg;
        hit_idx  = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_reg[i])
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
        end
        for (int j = 0; j < ENTRIES; j++)
        begin
            if (op_reg == OP_GET)
            begin
                rem_valid[j] = valid_reg[j];
                if (match_reg[j])
                begin
                    rem_rank[j] = '0;
                end
                else if (hit && valid_reg[j] && (rank_reg[j] < hit_rank))
                begin
                    rem_rank[j] = rank_reg[j] + RANK_W'(1);
                end
                else
                begin
                    rem_rank[j] = rank_reg[j];
                end
            end
            else
            begin
                rem_valid[j] = valid_reg[j] && !match_reg[j];
                if (hit && valid_reg[j] && (rank_reg[j] > hit_rank))
                begin
                    rem_rank[j] = rank_reg[j] - RANK_W'(1);
                end
                else
                begin
                    rem_rank[j] = rank_reg[j];
                end
            end
        end
        rem_occ = (op_reg == OP_PUT) ? occ_reg - OCC_W'(hit) : occ_reg;
    end

    // Eviction of the oldest ranks when full, then insert at the lowest free slot.
    always_comb
    begin
        full = (occ_reg >= cap_eff);
        for (int j = 0; j < ENTRIES; j++)
        begin
            ev_mask[j] = full && valid_reg[j] && (OCC_W'(rank_reg[j]) >= cap_m1);
        end
        kept_valid = valid_reg & ~ev_mask;
        kept_occ   = full ? cap_m1 : occ_reg;
        ins_idx    = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!kept_valid[i])
            begin
                ins_idx = IDX_W'(i);
            end
        end
        for (int j = 0; j < ENTRIES; j++)
        begin
            if (ins_idx == IDX_W'(j))
            begin
                ins_valid[j] = 1'b1;
                ins_rank[j]  = '0;
            end
            else
            begin
                ins_valid[j] = kept_valid[j];
                ins_rank[j]  = kept_valid[j] ? rank_reg[j] + RANK_W'(1) : rank_reg[j];
            end
        end
    end

    // Next store state by phase.
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        unique case (state_reg)
            S_REMOVE:
            begin
                valid_next = rem_valid;
                rank_next  = rem_rank;
                occ_next   = rem_occ;
            end
            S_INSERT:
            begin
                valid_next = ins_valid;
                rank_next  = ins_rank;
                occ_next   = kept_occ + OCC_W'(1);
            end
            S_IDLE, S_LOOKUP, S_FINISH:
            begin
                valid_next = valid_reg;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Value memory: read the hit entry, write the inserted one.
    always_comb
    begin
        ram_req.rd_en   = (state_reg == S_REMOVE);
        ram_req.rd_addr = hit_idx;
        ram_req.wr_en   = (state_reg == S_INSERT);
        ram_req.wr_addr = ins_idx;
        ram_req.wr_data = val_in_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_REMOVE;
            end
            S_REMOVE:
            begin
                state_next = (op_reg == OP_PUT) ? S_INSERT : S_FINISH;
            end
            S_INSERT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            rank_reg  <= rank_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg     <= req.op;
            key_in_reg <= req.key;
            val_in_reg <= req.value;
        end
        if (state_reg == S_LOOKUP)
        begin
            match_reg <= match_next;
        end
        if (state_reg == S_REMOVE)
        begin
            found_reg   <= hit;
            evicted_reg <= 1'b0;
        end
        if (state_reg == S_INSERT)
        begin
            evicted_reg <= |ev_mask;
        end
        for (int j = 0; j < ENTRIES; j++)
        begin
            if ((state_reg == S_INSERT) && (ins_idx == IDX_W'(j)))
            begin
                key_reg[j] <= key_in_reg;
            end
        end
        if (out_load)
        begin
            out_found_reg   <= found_reg;
            out_evicted_reg <= evicted_reg;
            if (op_reg == OP_PUT)
            begin
                out_value_reg <= '0;
            end
            else
            begin
                out_value_reg <= found_reg ? ram_rd_data : MISS_VALUE;
            end
        end
    end

    // Response outputs.
    assign resp.valid      = out_valid_reg;
    assign resp.found      = out_found_reg;
    assign resp.read_value = out_value_reg;
    assign resp.evicted    = out_evicted_reg;

`ifndef SYNTHESIS
    // Occupancy never exceeds the number of entries.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(ENTRIES))
        else $error("occupancy above entry count");

    // Keys are unique, so at most one entry matches.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE) |-> $onehot0(match_reg))
        else $error("more than one entry matched the key");

    // Between transactions the occupancy equals the number of valid entries.
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(valid_reg) == int'(occ_reg)))
        else $error("occupancy does not match valid entries");

    // An accepted request starts the lookup in the next cycle.
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_LOOKUP))
        else $error("accepted request did not start a lookup");
`endif

endmodule

>>> rtl/lrukv_value_ram.sv
module lrukv_value_ram (
    input  logic                        clk,
    input  lrukv_pkg::ram_req_t         req,
    output logic [lrukv_pkg::VAL_W-1:0] rd_data
);
    import lrukv_pkg::*;

    logic [VAL_W-1:0] mem [ENTRIES];
    logic [VAL_W-1:0] rd_data_reg;

    // One write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // One read port with registered data.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
